// ===== rtl/b64sc_pkg.sv =====
// Shared types, constants and alphabet functions for the Base64 stream codec.
// Used by b64sc_step and base64_stream_codec_core; no dependencies.
package b64sc_pkg;

	localparam int MAX_RESULTS = 4;
	localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DECODE_MODE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_URL_ALPHABET = 1'd1;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
		logic       stream_done;
		logic       bad_char;
	} out_item_t;

	typedef out_item_t [MAX_RESULTS-1:0] res_vec_t;

	typedef struct packed {
		logic [5:0] residue;
		logic [2:0] count;
		logic       pad_seen;
		logic       residue_bad;
	} strm_state_t;

	function automatic logic [7:0] code_to_char(input logic [5:0] code, input logic url);
		logic [7:0] c;
		c = {2'b00, code};
		if (code < 6'd26)
			return 8'd65 + c;
		else if (code < 6'd52)
			return 8'd71 + c;   // 'a' - 26
		else if (code < 6'd62)
			return c - 8'd4;    // '0' at code 52
		else if (code == 6'd62)
			return url ? 8'h2D : 8'h2B;
		else
			return url ? 8'h5F : 8'h2F;
	endfunction

	// bit 6 set marks a character outside the alphabet
	function automatic logic [6:0] char_to_code(input logic [7:0] ch, input logic url);
		if (ch >= 8'd65 && ch <= 8'd90)
			return 7'(ch - 8'd65);
		else if (ch >= 8'd97 && ch <= 8'd122)
			return 7'(ch - 8'd71);
		else if (ch >= 8'd48 && ch <= 8'd57)
			return 7'(ch + 8'd4);
		else if (url && ch == 8'h2D)
			return 7'd62;
		else if (url && ch == 8'h5F)
			return 7'd63;
		else if (!url && ch == 8'h2B)
			return 7'd62;
		else if (!url && ch == 8'h2F)
			return 7'd63;
		else
			return 7'd64;
	endfunction

endpackage

// ===== rtl/b64sc_step.sv =====
// Per-transaction codec logic: results and next stream state for one input item.
// Depends on b64sc_pkg.
module b64sc_step (
	input  logic                  decode_mode,
	input  logic                  url_alphabet,
	input  b64sc_pkg::strm_state_t st,
	input  b64sc_pkg::in_item_t   item,
	output b64sc_pkg::res_vec_t   res,
	output logic [b64sc_pkg::RES_CNT_W-1:0] n,
	output b64sc_pkg::strm_state_t st_nxt
);
	import b64sc_pkg::*;

	logic [RES_CNT_W-1:0] k;
	logic [RES_CNT_W-1:0] km1;
	logic [7:0]           b;
	logic                 eoi;
	logic [5:0]           rem;
	logic [2:0]           remb;
	logic [6:0]           dcode;
	logic [5:0]           code;
	logic                 cur_bad;
	logic [11:0]          acc12;

	always_comb begin
		res    = '0;
		k      = '0;
		km1    = '0;
		b      = item.data_byte;
		eoi    = item.end_of_input;
		st_nxt = st;
		rem    = '0;
		remb   = '0;
		dcode  = char_to_code(b, url_alphabet);
		code   = dcode[6] ? 6'd0 : dcode[5:0];
		cur_bad = dcode[6];
		acc12  = {st.residue, code};

		if (!decode_mode) begin
			unique case (st.count)
				3'd2: begin
					res[k[1:0]].out_byte = code_to_char({st.residue[1:0], b[7:4]}, url_alphabet);
					k    = k + 1'b1;
					rem  = {2'b00, b[3:0]};
					remb = 3'd4;
				end
				3'd4: begin
					res[k[1:0]].out_byte = code_to_char({st.residue[3:0], b[7:6]}, url_alphabet);
					k    = k + 1'b1;
					res[k[1:0]].out_byte = code_to_char(b[5:0], url_alphabet);
					k    = k + 1'b1;
					rem  = '0;
					remb = 3'd0;
				end
				default: begin
					res[k[1:0]].out_byte = code_to_char(b[7:2], url_alphabet);
					k    = k + 1'b1;
					rem  = {4'b0000, b[1:0]};
					remb = 3'd2;
				end
			endcase
			if (eoi) begin
				// zero-fill the leftover bits, then pad
				if (remb == 3'd2) begin
					res[k[1:0]].out_byte = code_to_char({rem[1:0], 4'b0000}, url_alphabet);
					k = k + 1'b1;
					res[k[1:0]].out_byte = PAD_CHAR;
					k = k + 1'b1;
					res[k[1:0]].out_byte = PAD_CHAR;
					k = k + 1'b1;
				end else if (remb == 3'd4) begin
					res[k[1:0]].out_byte = code_to_char({rem[3:0], 2'b00}, url_alphabet);
					k = k + 1'b1;
					res[k[1:0]].out_byte = PAD_CHAR;
					k = k + 1'b1;
				end
				st_nxt = '0;
			end else begin
				st_nxt.residue = rem;
				st_nxt.count   = remb;
			end
		end else begin
			if (!st.pad_seen) begin
				if (b == PAD_CHAR) begin
					st_nxt.pad_seen = 1'b1;
				end else begin
					unique case (st.count)
						3'd6: begin
							res[k[1:0]].out_byte = acc12[11:4];
							res[k[1:0]].bad_char = st.residue_bad | cur_bad;
							k = k + 1'b1;
							st_nxt.residue = {2'b00, code[3:0]};
							st_nxt.count   = 3'd4;
							st_nxt.residue_bad = cur_bad;
						end
						3'd4: begin
							res[k[1:0]].out_byte = acc12[9:2];
							res[k[1:0]].bad_char = st.residue_bad | cur_bad;
							k = k + 1'b1;
							st_nxt.residue = {4'b0000, code[1:0]};
							st_nxt.count   = 3'd2;
							st_nxt.residue_bad = cur_bad;
						end
						3'd2: begin
							res[k[1:0]].out_byte = acc12[7:0];
							res[k[1:0]].bad_char = st.residue_bad | cur_bad;
							k = k + 1'b1;
							st_nxt.residue = '0;
							st_nxt.count   = 3'd0;
							st_nxt.residue_bad = 1'b0;
						end
						default: begin
							st_nxt.residue = code;
							st_nxt.count   = 3'd6;
							st_nxt.residue_bad = cur_bad;
						end
					endcase
				end
			end
			if (eoi)
				st_nxt = '0;
		end

		// mark the final result of this transaction
		if (k != '0) begin
			km1 = k - 1'b1;
			res[km1[1:0]].last_of_run = 1'b1;
			res[km1[1:0]].stream_done = eoi;
		end
		n = k;
	end

endmodule

// ===== rtl/base64_stream_codec_core.sv =====
// Top level of the Base64 stream codec: configuration, stream state, result buffer.
// Depends on b64sc_pkg and b64sc_step.
//
// Streaming Base64 encoder/decoder. An accepted item produces zero to four result
// transactions, which are loaded into a result buffer in the cycle after acceptance
// and presented one per cycle on the output while out_stall is low. An ordinary
// byte yields one or two results in encode mode and up to four on the final byte;
// in decode mode an item yields at most one. The buffer takes a new item in the
// same cycle its last result leaves, so items with at most one result flow at one
// per cycle while the output is not stalled. The output buffer draining one result
// per cycle sets this rate. Configuration writes clear the stream state and must be
// issued only while no results are pending.
module base64_stream_codec_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [b64sc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [b64sc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  b64sc_pkg::in_item_t               in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output b64sc_pkg::out_item_t              out_data
);
	import b64sc_pkg::*;

	logic                 decode_mode_q;
	logic                 url_alphabet_q;
	strm_state_t          st_q;
	strm_state_t          st_nxt;
	res_vec_t             res;
	logic [RES_CNT_W-1:0] n;
	res_vec_t             res_s1;
	logic [RES_CNT_W-1:0] cnt_s1;
	logic                 in_take;
	logic                 out_take;

	b64sc_step u_step (
		.decode_mode  (decode_mode_q),
		.url_alphabet (url_alphabet_q),
		.st           (st_q),
		.item         (in_data),
		.res          (res),
		.n            (n),
		.st_nxt       (st_nxt)
	);

	assign out_valid = (cnt_s1 != '0);
	assign out_data  = res_s1[0];
	assign out_take  = out_valid && !out_stall;
	// accept when the buffer is empty or its last result leaves this cycle
	assign in_stall  = !((cnt_s1 == '0) || (cnt_s1 == RES_CNT_W'(1) && !out_stall));
	assign in_take   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_mode_q  <= 1'b0;
			url_alphabet_q <= 1'b0;
			st_q           <= '0;
			cnt_s1         <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_DECODE_MODE:  decode_mode_q  <= cfg_wdata[0];
					CFG_URL_ALPHABET: url_alphabet_q <= cfg_wdata[0];
				endcase
				st_q <= '0;
			end else if (in_take) begin
				st_q <= st_nxt;
			end
			if (in_take)
				cnt_s1 <= n;
			else if (out_take)
				cnt_s1 <= cnt_s1 - 1'b1;
		end
	end

	// result buffer payload: load on accept, advance on each output transaction
	always_ff @(posedge clk) begin
		if (in_take)
			res_s1 <= res;
		else if (out_take)
			res_s1 <= res_s1 >> $bits(out_item_t);
	end

endmodule
